// ----- design/mlts_pkg.sv -----
// mlts_pkg: shared constants and types for the truncation selection block
// no dependencies
package mlts_pkg;

  localparam int KEY_W        = 32;
  localparam int IDX_OUT_W    = 6;
  localparam int PARENTS_DEF  = 16;
  localparam int CHILDREN_DEF = 32;

  typedef struct packed {
    logic [IDX_OUT_W-1:0]    pool_index;
    logic signed [KEY_W-1:0] cost_value;
    logic                    last_survivor;
  } mlts_result_t;

endpackage

// ----- design/mlts_core.sv -----
// mlts_core: cost store, load counter and the shared scan/compare unit
// depends on mlts_pkg
module mlts_core import mlts_pkg::*; #(
  parameter int PARENTS  = PARENTS_DEF,
  parameter int CHILDREN = CHILDREN_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    plus_mode,
  input  logic                    in_take,
  input  logic signed [KEY_W-1:0] in_key,
  output logic                    in_ready,
  output logic                    res_valid,
  output mlts_result_t            res,
  input  logic                    res_take
);

  localparam int POOL   = PARENTS + CHILDREN;
  localparam int IW     = $clog2(POOL);
  localparam int KW     = $clog2(PARENTS);
  localparam int NCOMMA = (CHILDREN < PARENTS) ? CHILDREN : PARENTS;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]              state;
  logic [IW-1:0]           load_count;
  logic                    mode;
  logic [IW-1:0]           rd_addr;
  logic                    issuing;
  logic                    rd_vld;
  logic [IW-1:0]           rd_idx;
  logic signed [KEY_W-1:0] rd_data;
  logic                    have_prev;
  logic signed [KEY_W-1:0] prev_key;
  logic [IW-1:0]           prev_idx;
  logic                    have_best;
  logic signed [KEY_W-1:0] best_key;
  logic [IW-1:0]           best_idx;
  logic [KW-1:0]           k;
  logic [KW-1:0]           k_last;
  logic                    above_prev;
  logic                    better;
  logic                    upd;
  logic [IW-1:0]           first_idx;

  logic [KEY_W-1:0] mem [POOL];

  assign first_idx = mode ? '0 : IW'(PARENTS);
  assign k_last    = mode ? KW'(PARENTS - 1) : KW'(NCOMMA - 1);

  assign above_prev = !have_prev || (rd_data > prev_key) ||
                      ((rd_data == prev_key) && (rd_idx > prev_idx));
  assign better     = !have_best || (rd_data < best_key);
  assign upd        = rd_vld && above_prev && better;

  // store write on load, registered read during scan
  always_ff @(posedge clk) begin
    if (state == ST_LOAD && in_take) begin
      mem[load_count] <= in_key;
    end
    if (issuing) begin
      rd_data <= mem[rd_addr];
    end
    rd_idx <= rd_addr;
    if (upd) begin
      best_key <= rd_data;
      best_idx <= rd_idx;
    end
    if (state == ST_HOLD && res_take) begin
      prev_key <= best_key;
      prev_idx <= best_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      mode       <= 1'b1;
      rd_addr    <= '0;
      issuing    <= 1'b0;
      rd_vld     <= 1'b0;
      have_prev  <= 1'b0;
      have_best  <= 1'b0;
      k          <= '0;
    end else begin
      rd_vld <= issuing;
      case (state)
        ST_LOAD: begin
          if (in_take) begin
            if (load_count == IW'(POOL - 1)) begin
              load_count <= '0;
              mode       <= plus_mode;
              rd_addr    <= plus_mode ? '0 : IW'(PARENTS);
              issuing    <= 1'b1;
              have_prev  <= 1'b0;
              have_best  <= 1'b0;
              k          <= '0;
              state      <= ST_SCAN;
            end else begin
              load_count <= load_count + 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (issuing) begin
            if (rd_addr == IW'(POOL - 1)) begin
              issuing <= 1'b0;
            end else begin
              rd_addr <= rd_addr + 1'b1;
            end
          end
          if (upd) begin
            have_best <= 1'b1;
          end
          if (rd_vld && rd_idx == IW'(POOL - 1)) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (res_take) begin
            have_prev <= 1'b1;
            if (k == k_last) begin
              state <= ST_LOAD;
            end else begin
              k         <= k + 1'b1;
              rd_addr   <= first_idx;
              issuing   <= 1'b1;
              have_best <= 1'b0;
              state     <= ST_SCAN;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  assign in_ready          = (state == ST_LOAD);
  assign res_valid         = (state == ST_HOLD);
  assign res.pool_index    = IDX_OUT_W'(best_idx);
  assign res.cost_value    = best_key;
  assign res.last_survivor = (k == k_last);

endmodule

// ----- design/mu_lambda_truncation_selection.sv -----
// mu_lambda_truncation_selection: survivor selection by truncation, top level
// depends on mlts_pkg and mlts_core
//
// s_axis carries one cost key per item, pool order: PARENTS parents first,
// then CHILDREN children. s_tready is high while the pool loads, so loading
// takes one item per cycle. the item that completes the pool starts the
// selection, and s_tready stays low until the final survivor has moved into
// the output register.
// m_axis then gives PARENTS survivors (CHILDREN if comma mode offers fewer)
// in ascending cost, ties by lower pool index, tlast on the final one.
// each survivor is one full pass of the shared compare unit over the
// candidates through the single read port of the cost store; the candidates
// are all PARENTS + CHILDREN in plus mode, the CHILDREN in comma mode. a round
// is the load of the pool followed by one such pass per survivor.
// plus_mode is written through cfg_we / cfg_wdata and sampled when the pool
// completes. reset clears the load count and sets plus mode; the store
// needs no clearing. when m_tready is low the survivor waits in the output
// register, and the next survivor is found and then waits in the core.
module mu_lambda_truncation_selection import mlts_pkg::*; #(
  parameter int PARENTS  = PARENTS_DEF,
  parameter int CHILDREN = CHILDREN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // cost_key
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // pool_index[5:0], cost_value[37:6], zero pad
  output logic        m_tlast    // last_survivor
);

  logic         plus_mode;
  logic         core_ready;
  logic         res_valid;
  logic         res_take;
  mlts_result_t res;
  mlts_result_t out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      plus_mode <= 1'b1;
    end else if (cfg_we) begin
      plus_mode <= cfg_wdata;
    end
  end

  mlts_core #(
    .PARENTS  (PARENTS),
    .CHILDREN (CHILDREN)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .plus_mode (plus_mode),
    .in_take   (s_tvalid && core_ready),
    .in_key    (s_tdata),
    .in_ready  (core_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  assign res_take = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_reg <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign s_tready = core_ready;
  assign m_tdata  = {2'b00, out_reg.cost_value, out_reg.pool_index};
  assign m_tlast  = out_reg.last_survivor;

endmodule

// ----- bench/mlts_checker.sv -----
// mlts_checker: watches the cost and survivor channels of the truncation selection block,
// keeps its own copy of the pool and mode, predicts the survivors and compares them
// depends on mlts_pkg
`timescale 1ns / 100ps

module mlts_checker import mlts_pkg::*; #(
  parameter int PARENTS  = PARENTS_DEF,
  parameter int CHILDREN = CHILDREN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // cost_key
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // pool_index[5:0], cost_value[37:6], zero pad
  input  logic        m_tlast,   // last_survivor
  output int          pending,
  output int          fail_count
);

  localparam int POOL   = PARENTS + CHILDREN;
  localparam int QDEPTH = 64;

  logic signed [KEY_W-1:0] cost_pool [POOL];
  bit                      taken [POOL];
  int                      fill_count;
  logic                    plus_sel;
  int                      survivors_seen;
  mlts_result_t            want_buf [QDEPTH];
  int                      wr_ptr;
  int                      rd_ptr;
  int                      want_count;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] survivor %0d: %s got %0h expected %0h", $realtime, survivors_seen,
             what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    int           first;
    int           n_out;
    int           best;
    int           i;
    int           k;
    mlts_result_t want;
    mlts_result_t got;
    if (rst) begin
      fill_count = 0;
      plus_sel = 1'b1;
      fail_count = 0;
      survivors_seen = 0;
      wr_ptr = 0;
      rd_ptr = 0;
      want_count = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        cost_pool[fill_count] = $signed(s_tdata);
        fill_count++;
        if (fill_count == POOL) begin
          fill_count = 0;
          first = plus_sel ? 0 : PARENTS;
          n_out = (POOL - first < PARENTS) ? POOL - first : PARENTS;
          for (i = 0; i < POOL; i++) taken[i] = 1'b0;
          // repeated minimum search, strict compare keeps the lower index on ties
          for (k = 0; k < n_out; k++) begin
            best = -1;
            for (i = first; i < POOL; i++) begin
              if (!taken[i]) begin
                if (best < 0) best = i;
                else if (cost_pool[i] < cost_pool[best]) best = i;
              end
            end
            taken[best] = 1'b1;
            want.pool_index = IDX_OUT_W'(best);
            want.cost_value = cost_pool[best];
            want.last_survivor = (k + 1 == n_out);
            want_buf[wr_ptr] = want;
            wr_ptr = (wr_ptr + 1) % QDEPTH;
            want_count++;
          end
        end
      end

      // mode register takes effect after the item of the same edge
      if (cfg_we) plus_sel = cfg_wdata;

      if (m_tvalid && m_tready) begin
        got.pool_index = m_tdata[IDX_OUT_W-1:0];
        got.cost_value = m_tdata[IDX_OUT_W +: KEY_W];
        got.last_survivor = m_tlast;
        if (want_count == 0) begin
          report_mismatch("unexpected item", {24'd0, m_tdata}, 64'd0);
        end else begin
          want = want_buf[rd_ptr];
          rd_ptr = (rd_ptr + 1) % QDEPTH;
          want_count--;
          if (got.pool_index !== want.pool_index)
            report_mismatch("pool_index", 64'(got.pool_index), 64'(want.pool_index));
          if (got.cost_value !== want.cost_value)
            report_mismatch("cost_value", 64'(got.cost_value), 64'(want.cost_value));
          if (got.last_survivor !== want.last_survivor)
            report_mismatch("last_survivor", 64'(got.last_survivor),
                            64'(want.last_survivor));
        end
        survivors_seen++;
      end
    end
    pending <= want_count;
  end

endmodule

// ----- bench/testbench.sv -----
// testbench: drives pools of cost keys into mu_lambda_truncation_selection in bursts,
// switches plus and comma mode between rounds, and gives the verdict
// depends on mlts_pkg, mlts_checker and the block itself
`timescale 1ns / 100ps

module testbench;
  import mlts_pkg::*;

  localparam int PARENTS  = PARENTS_DEF;
  localparam int CHILDREN = CHILDREN_DEF;
  localparam int POOL     = PARENTS + CHILDREN;
  localparam int ROUNDS   = 5;
  localparam int LIMIT    = 200000;
  localparam int HOLD_AT  = 2 * PARENTS + 4;
  localparam int HOLD_LEN = 400;

  localparam int KEYS_RANDOM    = 0;
  localparam int KEYS_TIES      = 1;
  localparam int KEYS_LOW_PARENTS = 2;
  localparam int KEYS_EXTREMES  = 3;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // cost_key
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // pool_index[5:0], cost_value[37:6], zero pad
  logic        m_tlast;   // last_survivor
  int          pending;
  int          fail_count;
  int          burst_left;
  int          cycles;

  logic [31:0] corner_keys [24] = '{
    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
    32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
    32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0001, 32'h7FFF_FFFE,
    32'hFFFF_FFFE, 32'h0000_0002, 32'hFFFF_FFFF, 32'h8000_0000,
    32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
    32'h4000_0000, 32'hC000_0000, 32'h8000_0000, 32'h0000_0001
  };
  int   round_style [ROUNDS] = '{KEYS_TIES, KEYS_LOW_PARENTS, KEYS_RANDOM,
                                 KEYS_EXTREMES, KEYS_TIES};
  logic round_mode  [ROUNDS] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

  mu_lambda_truncation_selection #(
    .PARENTS  (PARENTS),
    .CHILDREN (CHILDREN)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  mlts_checker #(
    .PARENTS  (PARENTS),
    .CHILDREN (CHILDREN)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** mu_lambda_truncation_selection: FAILED **");
    $finish;
  end

  task automatic send_key(input logic [31:0] key);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= key;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
  endtask

  // waits for every survivor of the last round before touching the mode
  task automatic set_plus_mode(input logic mode);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : sink
    int accepted;
    int phase;
    int held;
    bit hold_done;
    m_tready <= 1'b0;
    accepted = 0;
    phase = 0;
    hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) accepted++;
      phase = (phase + 1) % 64;
      if (!hold_done && accepted == HOLD_AT) begin
        // long hold-off while the next pool is already being offered
        hold_done = 1'b1;
        m_tready <= 1'b0;
        for (held = 0; held < HOLD_LEN; held++) @(posedge clk);
      end else if (phase < 16) begin
        m_tready <= 1'b1;
      end else if (phase < 40) begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end else begin
        m_tready <= ($urandom_range(0, 1) == 0);
      end
    end
  end

  initial begin : stimulus
    int          r;
    int          i;
    logic [31:0] key;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= 1'b0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < ROUNDS; r++) begin
      // round 3 follows round 2 without a pause so the sender runs into the hold-off
      if (r != 3) set_plus_mode(round_mode[r]);
      for (i = 0; i < POOL; i++) begin
        if (r == 0 && i < 24) begin
          key = corner_keys[i];
        end else begin
          case (round_style[r])
            KEYS_TIES:        key = 32'($urandom_range(0, 7)) - 32'd4;
            KEYS_LOW_PARENTS: key = (i < PARENTS) ? 32'h8000_0000 + $urandom_range(0, 3)
                                                  : $urandom();
            KEYS_EXTREMES: begin
              case ($urandom_range(0, 4))
                0:       key = 32'h8000_0000;
                1:       key = 32'h7FFF_FFFF;
                2:       key = 32'h0000_0000;
                3:       key = 32'hFFFF_FFFF;
                default: key = $urandom();
              endcase
            end
            default:          key = $urandom();
          endcase
        end
        send_key(key);
      end
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0)
      $display("** mu_lambda_truncation_selection: PASSED **");
    else
      $display("** mu_lambda_truncation_selection: FAILED **");
    $finish;
  end

endmodule
